>>> rtl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg: shared types and codes of the positional list store
// Beat layouts, command and status codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pls_pkg;

    localparam int CMD_W     = 3;
    localparam int POS_W     = 5;
    localparam int WORD_W    = 32;
    localparam int CNT_OUT_W = 5;
    localparam int ST_W      = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [POS_W-1:0]  position;
        logic [WORD_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0]    word_out;
        logic [CNT_OUT_W-1:0] count_out;
        logic [ST_W-1:0]      status;
    } rsp_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_COUNT,
        IDX_POS,
        IDX_INC,
        IDX_DEC
    } idx_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLEAR
    } cnt_op_t;

    typedef enum logic [1:0] {
        RD_POS,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic {
        WR_VALUE,
        WR_SHIFT
    } wr_sel_t;

    typedef struct packed {
        logic            take;
        logic            set_status;
        logic [ST_W-1:0] status_val;
        idx_op_t         idx_op;
        cnt_op_t         cnt_op;
        rd_sel_t         rd_sel;
        logic            wr_en;
        wr_sel_t         wr_sel;
        logic            word_cap;
        logic            out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic             in_valid;
        logic [CMD_W-1:0] cmd;
        logic             full;
        logic             pos_gt_cnt;
        logic             pos_ge_cnt;
        logic             up_more;
        logic             dn_more_now;
        logic             dn_more_next;
        logic             out_free;
    } ctrl_sts_t;

endpackage

>>> rtl/pls_stream_if.sv
// ----------------------------------------------------------------------------
// pls_stream_if: valid/ready channel
// Carries one payload beat per handshake from a source to a sink.
// ----------------------------------------------------------------------------
interface pls_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

>>> rtl/pls_ram.sv
// ----------------------------------------------------------------------------
// pls_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/pls_ctrl.sv
// ----------------------------------------------------------------------------
// pls_ctrl: command sequencer of the positional list store
// Decodes each command, walks the entry moves for insert and remove one
// entry at a time, and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module pls_ctrl
    import pls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t ctl
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EVAL  = 7'b0000010,
        S_SH_RD = 7'b0000100,
        S_SH_WR = 7'b0001000,
        S_PUT   = 7'b0010000,
        S_FETCH = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctl.take       = 1'b0;
        ctl.set_status = 1'b0;
        ctl.status_val = ST_OK;
        ctl.idx_op     = IDX_HOLD;
        ctl.cnt_op     = CNT_HOLD;
        ctl.rd_sel     = RD_POS;
        ctl.wr_en      = 1'b0;
        ctl.wr_sel     = WR_VALUE;
        ctl.word_cap   = 1'b0;
        ctl.out_load   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                ctl.take = 1'b1;
                if (sts.in_valid)
                begin
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                case (sts.cmd)
                    CMD_INSERT:
                    begin
                        if (sts.full)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status_val = ST_FULL;
                            state_next     = S_RESP;
                        end
                        else if (sts.pos_gt_cnt)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status_val = ST_RANGE;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            ctl.idx_op = IDX_COUNT;
                            state_next = sts.pos_ge_cnt ? S_PUT : S_SH_RD;
                        end
                    end

                    CMD_APPEND:
                    begin
                        if (sts.full)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status_val = ST_FULL;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            ctl.idx_op = IDX_COUNT;
                            state_next = S_PUT;
                        end
                    end

                    CMD_REMOVE, CMD_READ:
                    begin
                        if (sts.pos_ge_cnt)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status_val = ST_RANGE;
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            ctl.idx_op = IDX_POS;
                            ctl.rd_sel = RD_POS;
                            state_next = S_FETCH;
                        end
                    end

                    CMD_CLEAR:
                    begin
                        ctl.cnt_op = CNT_CLEAR;
                        state_next = S_RESP;
                    end

                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end

            S_SH_RD:
            begin
                // Insert moves entries up, so it reads the one below the
                // current slot; remove reads the one above.
                ctl.rd_sel = (sts.cmd == CMD_INSERT) ? RD_PREV : RD_NEXT;
                state_next = S_SH_WR;
            end

            S_SH_WR:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = WR_SHIFT;
                if (sts.cmd == CMD_INSERT)
                begin
                    ctl.idx_op = IDX_DEC;
                    state_next = sts.up_more ? S_SH_RD : S_PUT;
                end
                else
                begin
                    ctl.idx_op = IDX_INC;
                    if (sts.dn_more_next)
                    begin
                        state_next = S_SH_RD;
                    end
                    else
                    begin
                        ctl.cnt_op = CNT_DEC;
                        state_next = S_RESP;
                    end
                end
            end

            S_PUT:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = WR_VALUE;
                ctl.cnt_op = CNT_INC;
                state_next = S_RESP;
            end

            S_FETCH:
            begin
                ctl.word_cap = 1'b1;
                if (sts.cmd == CMD_READ)
                begin
                    state_next = S_RESP;
                end
                else if (sts.dn_more_now)
                begin
                    state_next = S_SH_RD;
                end
                else
                begin
                    ctl.cnt_op = CNT_DEC;
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/pls_datapath.sv
// ----------------------------------------------------------------------------
// pls_datapath: storage and arithmetic of the positional list store
// Holds the request registers, entry count, walk index, the list memory and
// the output register, and reports the comparisons the sequencer needs.
// ----------------------------------------------------------------------------
module pls_datapath
    import pls_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    pls_stream_if.sink    req,
    pls_stream_if.source  rsp,
    input  ctrl_cmd_t     ctl,
    output ctrl_sts_t     sts
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [CMD_W-1:0]  cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [WORD_W-1:0] val_reg;
    logic [WORD_W-1:0] word_reg;
    logic [ST_W-1:0]   status_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     idx_next;
    logic              out_valid_reg;
    rsp_t              out_reg;

    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     idx_x;
    logic [XW-1:0]     rd_addr_x;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] ram_wdata;
    logic              load;

    assign load  = ctl.take && req.valid;
    assign pos_x = XW'(pos_reg);
    assign cnt_x = XW'(cnt_reg);
    assign idx_x = XW'(idx_reg);

    assign req.ready   = ctl.take;
    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_reg;

    assign sts.in_valid     = req.valid;
    assign sts.cmd          = cmd_reg;
    assign sts.full         = (cnt_x >= XW'(CAPACITY));
    assign sts.pos_gt_cnt   = (pos_x > cnt_x);
    assign sts.pos_ge_cnt   = (pos_x >= cnt_x);
    assign sts.up_more      = (idx_x > pos_x + XW'(1));
    assign sts.dn_more_now  = (idx_x + XW'(1) < cnt_x);
    assign sts.dn_more_next = (idx_x + XW'(2) < cnt_x);
    assign sts.out_free     = !out_valid_reg || rsp.ready;

    always_comb
    begin
        case (ctl.rd_sel)
            RD_PREV: rd_addr_x = idx_x - XW'(1);
            RD_NEXT: rd_addr_x = idx_x + XW'(1);
            default: rd_addr_x = pos_x;
        endcase
    end

    assign ram_wdata = (ctl.wr_sel == WR_SHIFT) ? ram_rdata : val_reg;

    always_comb
    begin
        case (ctl.idx_op)
            IDX_COUNT: idx_next = cnt_reg;
            IDX_POS:   idx_next = pos_x[CW-1:0];
            IDX_INC:   idx_next = idx_reg + CW'(1);
            IDX_DEC:   idx_next = idx_reg - CW'(1);
            default:   idx_next = idx_reg;
        endcase
    end

    always_comb
    begin
        case (ctl.cnt_op)
            CNT_INC:   cnt_next = cnt_reg + CW'(1);
            CNT_DEC:   cnt_next = cnt_reg - CW'(1);
            CNT_CLEAR: cnt_next = '0;
            default:   cnt_next = cnt_reg;
        endcase
    end

    pls_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ctl.wr_en),
        .waddr (idx_reg[AW-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_addr_x[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (load)
        begin
            cmd_reg    <= req.payload.cmd;
            pos_reg    <= req.payload.position;
            val_reg    <= req.payload.value;
            word_reg   <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (ctl.word_cap)
            begin
                word_reg <= ram_rdata;
            end
            if (ctl.set_status)
            begin
                status_reg <= ctl.status_val;
            end
        end
        if (ctl.out_load)
        begin
            out_reg.word_out  <= word_reg;
            out_reg.count_out <= cnt_x[CNT_OUT_W-1:0];
            out_reg.status    <= status_reg;
        end
    end

endmodule

>>> rtl/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store: ordered list of 32-bit words with positional access
// Insert, append, remove, read and clear on a list of up to CAPACITY words.
// ----------------------------------------------------------------------------
// The block takes one command at a time and returns exactly one result beat
// per command beat. The words live in a single-port-write, registered-read
// memory, so insert and remove move each affected entry by reading it and
// then writing it one slot further. A new command is taken in the cycle
// after the result is loaded into the output register, even while that
// result still waits to be taken. Words that have never been written read
// back as undefined, but only live positions can be read.
module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    pls_stream_if.sink   req,
    pls_stream_if.source rsp
);

    ctrl_cmd_t ctl;
    ctrl_sts_t sts;

    pls_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    pls_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .ctl   (ctl),
        .sts   (sts)
    );

endmodule

>>> tb/positional_list_store_tb.sv
// ----------------------------------------------------------------------------
// positional_list_store_tb: self-checking testbench of the positional list store
// Drives command beats into the request channel, predicts each result from a
// shadow copy of the list and its count, and compares every result beat field
// by field. Directed tests cover the empty list, the basic operations and a
// full list. Random traffic mixes well-formed commands, out-of-range positions,
// unknown commands and clears; all but the calm run stall both sides at random.
// ----------------------------------------------------------------------------
module positional_list_store_tb
    import pls_pkg::*;
();

    localparam int CAPACITY   = 16;
    localparam int AW         = $clog2(CAPACITY);
    localparam int CYCLE_CAP  = 500000;
    localparam int DRAIN_WAIT = 40;

    logic clk = 1'b0;
    logic rst_n;

    always #5 clk = ~clk;

    pls_stream_if #(.payload_t(req_t)) req_if ();
    pls_stream_if #(.payload_t(rsp_t)) rsp_if ();

    positional_list_store #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if.sink),
        .rsp   (rsp_if.source)
    );

    // Shadow of the list contents and of the live count.
    logic [WORD_W-1:0] shadow_words [CAPACITY];
    int                shadow_count;

    rsp_t expected_rsp_q [$];
    rsp_t front_rsp;

    int  error_count;
    int  checked_count;
    int  cycle_count;
    bit  no_stall;
    int  cmd_tally [8];
    int  status_tally [4];

    // Applies one command to the shadow list and returns the result it causes.
    function automatic rsp_t apply_list_cmd(input req_t r);
        rsp_t o;
        int   k;
        o.word_out = '0;
        o.status   = ST_OK;
        case (r.cmd)
            CMD_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                    o.status = ST_FULL;
                else if (int'(r.position) > shadow_count)
                    o.status = ST_RANGE;
                else
                begin
                    for (k = shadow_count; k > int'(r.position); k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[r.position[AW-1:0]] = r.value;
                    shadow_count++;
                end
            end
            CMD_APPEND:
            begin
                if (shadow_count >= CAPACITY)
                    o.status = ST_FULL;
                else
                begin
                    shadow_words[shadow_count] = r.value;
                    shadow_count++;
                end
            end
            CMD_REMOVE:
            begin
                if (int'(r.position) >= shadow_count)
                    o.status = ST_RANGE;
                else
                begin
                    o.word_out = shadow_words[r.position[AW-1:0]];
                    for (k = int'(r.position); k + 1 < shadow_count; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_count--;
                end
            end
            CMD_READ:
            begin
                if (int'(r.position) >= shadow_count)
                    o.status = ST_RANGE;
                else
                    o.word_out = shadow_words[r.position[AW-1:0]];
            end
            CMD_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        o.count_out = CNT_OUT_W'(shadow_count);
        return o;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, so the next beat can follow without a gap.
    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                            input logic [WORD_W-1:0] v);
        req_t r;
        rsp_t e;
        r.cmd      = c;
        r.position = p;
        r.value    = v;
        if (!no_stall)
        begin
            while ($urandom_range(0, 99) < 14)
            begin
                req_if.valid <= 1'b0;
                @(negedge clk);
            end
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        e = apply_list_cmd(r);
        expected_rsp_q.push_back(e);
        cmd_tally[c]++;
        status_tally[e.status]++;
        @(negedge clk);
    endtask

    task automatic test_empty_list();
        send_cmd(CMD_READ,   5'd0,  32'h0000_0000);
        send_cmd(CMD_REMOVE, 5'd0,  32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 5'd1,  32'hFFFF_FFFF);
        send_cmd(CMD_READ,   5'd31, 32'h0000_0000);
        send_cmd(CMD_REMOVE, 5'd16, 32'h0000_0000);
    endtask

    task automatic test_basic_ops();
        send_cmd(CMD_INSERT, 5'd0, 32'h0000_0000);
        send_cmd(CMD_APPEND, 5'd31, 32'hFFFF_FFFF);
        send_cmd(CMD_INSERT, 5'd1, 32'h7F80_0000);
        // Inserting at a position equal to the count behaves as an append.
        send_cmd(CMD_INSERT, 5'd3, 32'h8000_0000);
        send_cmd(CMD_INSERT, 5'd5, 32'h3F80_0000);
        send_cmd(CMD_READ,   5'd1, 32'h0000_0000);
        send_cmd(CMD_READ,   5'd3, 32'h0000_0000);
        send_cmd(CMD_REMOVE, 5'd1, 32'h0000_0000);
        send_cmd(CMD_READ,   5'd1, 32'h0000_0000);
        send_cmd(CMD_REMOVE, 5'd2, 32'h0000_0000);
        send_cmd(3'd5, 5'd0,  32'h1234_5678);
        send_cmd(3'd6, 5'd31, 32'hFFFF_FFFF);
        send_cmd(3'd7, 5'd16, 32'h0000_0000);
        send_cmd(CMD_CLEAR,  5'd0, 32'h0000_0000);
    endtask

    task automatic test_full_list();
        int k;
        // Inserting at the head moves every live entry, so every insert of the fill
        // shifts the whole list.
        for (k = 0; k < CAPACITY; k++)
            send_cmd((k % 2) ? CMD_APPEND : CMD_INSERT, 5'd0, 32'h3F80_0000 + k);
        // A full list is reported before an out-of-range position.
        send_cmd(CMD_INSERT, 5'd31, 32'hDEAD_BEEF);
        send_cmd(CMD_APPEND, 5'd0,  32'hDEAD_BEEF);
        send_cmd(CMD_REMOVE, 5'd0,  32'h0000_0000);
        send_cmd(CMD_INSERT, 5'd0,  32'hC000_0000);
        send_cmd(CMD_READ,   5'd15, 32'h0000_0000);
        send_cmd(CMD_REMOVE, 5'd15, 32'h0000_0000);
        send_cmd(CMD_READ,   5'd15, 32'h0000_0000);
        send_cmd(CMD_CLEAR,  5'd0,  32'h0000_0000);
        send_cmd(CMD_READ,   5'd0,  32'h0000_0000);
    endtask

    task automatic test_random_traffic(input int n_items, input bit calm);
        int                i;
        int                roll;
        int                grow_bias;
        logic [CMD_W-1:0]  c;
        logic [POS_W-1:0]  p;
        logic [WORD_W-1:0] v;
        no_stall  = calm;
        grow_bias = 60;
        for (i = 0; i < n_items; i++)
        begin
            // The bias drifts so that the list swings between empty and full.
            if (i % 64 == 0)
                grow_bias = $urandom_range(25, 85);
            case ($urandom_range(0, 15))
                0:       v = 32'h0000_0000;
                1:       v = 32'hFFFF_FFFF;
                2:       v = 32'h7F80_0000;
                3:       v = 32'h7FC0_0001;
                4:       v = 32'h8000_0000;
                default: v = $urandom;
            endcase
            p    = POS_W'($urandom_range(0, 31));
            roll = $urandom_range(0, 99);
            if (roll < 2)
                c = CMD_CLEAR;
            else if (roll < 5)
                c = 3'($urandom_range(5, 7));
            else if (roll < 11)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        c = CMD_INSERT;
                        p = POS_W'($urandom_range(shadow_count + 1, 31));
                    end
                    1:
                    begin
                        c = CMD_REMOVE;
                        p = POS_W'($urandom_range(shadow_count, 31));
                    end
                    default:
                    begin
                        c = CMD_READ;
                        p = POS_W'($urandom_range(shadow_count, 31));
                    end
                endcase
            end
            else if ($urandom_range(0, 99) < grow_bias)
            begin
                c = $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT;
                if (c == CMD_INSERT)
                    p = POS_W'($urandom_range(0, shadow_count));
            end
            else
            begin
                c = $urandom_range(0, 1) ? CMD_READ : CMD_REMOVE;
                if (shadow_count > 0)
                    p = POS_W'($urandom_range(0, shadow_count - 1));
            end
            send_cmd(c, p, v);
        end
        no_stall = 1'b0;
    endtask

    // Result sink: ready is redrawn at every falling edge.
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_if.ready <= no_stall ? 1'b1 : ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                error_count++;
                $display("%0t: result beat with no command outstanding, actual %h",
                         $time, rsp_if.payload);
            end
            else
            begin
                front_rsp = expected_rsp_q.pop_front();
                checked_count++;
                if (rsp_if.payload.word_out !== front_rsp.word_out)
                begin
                    error_count++;
                    $display("%0t: word_out mismatch, expected %h, actual %h",
                             $time, front_rsp.word_out, rsp_if.payload.word_out);
                end
                if (rsp_if.payload.count_out !== front_rsp.count_out)
                begin
                    error_count++;
                    $display("%0t: count_out mismatch, expected %0d, actual %0d",
                             $time, front_rsp.count_out, rsp_if.payload.count_out);
                end
                if (rsp_if.payload.status !== front_rsp.status)
                begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, front_rsp.status, rsp_if.payload.status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("%0t: timed out with %0d results outstanding",
                     $time, expected_rsp_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        shadow_count   = 0;
        error_count    = 0;
        checked_count  = 0;
        cycle_count    = 0;
        no_stall       = 1'b0;
        foreach (shadow_words[k])
            shadow_words[k] = '0;
        foreach (cmd_tally[k])
            cmd_tally[k] = 0;
        foreach (status_tally[k])
            status_tally[k] = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_random_traffic(700, 1'b0);
        test_random_traffic(300, 1'b1);
        test_random_traffic(600, 1'b0);

        req_if.valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Checked %0d result beats: %0d insert, %0d append, %0d remove, %0d read,",
                 checked_count, cmd_tally[CMD_INSERT], cmd_tally[CMD_APPEND],
                 cmd_tally[CMD_REMOVE], cmd_tally[CMD_READ]);
        $display("%0d clear, %0d unknown; %0d refused as full, %0d out of range.",
                 cmd_tally[CMD_CLEAR], cmd_tally[5] + cmd_tally[6] + cmd_tally[7],
                 status_tally[ST_FULL], status_tally[ST_RANGE]);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> sim.f
rtl/pls_pkg.sv
rtl/pls_stream_if.sv
rtl/pls_ram.sv
rtl/pls_ctrl.sv
rtl/pls_datapath.sv
rtl/positional_list_store.sv
tb/positional_list_store_tb.sv
